// ===== rtl/cee_pkg.sv =====
package cee_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int MAX_DIGITS = 18;
  localparam int MANT_W = 60;
  localparam int FD_W = 5;
  localparam int MAG_W = 129;
  localparam int MUL_STEPS = 64;

  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_TIMES = 8'h2A;
  localparam logic [7:0] CH_DIVIDE = 8'h2F;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam int ERR_DIV0 = 0;
  localparam int ERR_OVF = 1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef enum logic [2:0] {
    OP_PLUS = 3'd0,
    OP_MINUS = 3'd1,
    OP_TIMES = 3'd2,
    OP_DIVIDE = 3'd3,
    OP_NONE = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_OPER,
    S_MUL,
    S_DIV,
    S_ROUND,
    S_PACK,
    S_FIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clr_token;
    logic tok_zero;
    logic tok_sat;
    logic tdiv_init;
    logic div_init;
    logic div_step;
    logic mul_init;
    logic mul_step;
    logic do_round;
    logic round_mul;
    logic do_pack;
    logic pack_operand;
    logic addsub;
    logic div_zero;
    logic set_pending;
    logic emit;
  } cee_cmd_t;

  typedef struct packed {
    logic ends;
    logic last;
    logic tok_present;
    logic tok_two_points;
    logic tok_big;
    logic den_zero;
    logic out_busy;
    op_t  pending;
  } cee_stat_t;

  function automatic logic [63:0] pow10(input logic [FD_W-1:0] n);
    logic [63:0] v;
    unique case (n)
      5'd0: v = 64'd1;
      5'd1: v = 64'd10;
      5'd2: v = 64'd100;
      5'd3: v = 64'd1000;
      5'd4: v = 64'd10000;
      5'd5: v = 64'd100000;
      5'd6: v = 64'd1000000;
      5'd7: v = 64'd10000000;
      5'd8: v = 64'd100000000;
      5'd9: v = 64'd1000000000;
      5'd10: v = 64'd10000000000;
      5'd11: v = 64'd100000000000;
      5'd12: v = 64'd1000000000000;
      5'd13: v = 64'd10000000000000;
      5'd14: v = 64'd100000000000000;
      5'd15: v = 64'd1000000000000000;
      5'd16: v = 64'd10000000000000000;
      5'd17: v = 64'd100000000000000000;
      5'd18: v = 64'd1000000000000000000;
      default: v = 64'd1;
    endcase
    return v;
  endfunction

  localparam logic [63:0] DIGIT_LIMIT = pow10(FD_W'(MAX_DIGITS));

  function automatic op_t op_code(input logic [7:0] c);
    op_t o;
    priority if (c == CH_PLUS) o = OP_PLUS;
    else if (c == CH_MINUS) o = OP_MINUS;
    else if (c == CH_TIMES) o = OP_TIMES;
    else if (c == CH_DIVIDE) o = OP_DIVIDE;
    else o = OP_NONE;
    return o;
  endfunction

endpackage

// ===== rtl/cee_ctrl.sv =====
module cee_ctrl #(
  parameter int FRAC_BITS = cee_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cee_pkg::cee_stat_t stat,
  output cee_pkg::cee_cmd_t  cmd
);
  import cee_pkg::*;

  localparam int NUM_W = 64 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic use_mul, use_mul_next;
  logic to_operand, to_operand_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      use_mul <= 1'b0;
      to_operand <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      use_mul <= use_mul_next;
      to_operand <= to_operand_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    use_mul_next = use_mul;
    to_operand_next = to_operand;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.ends) begin
          state_next = S_IDLE;
        end else begin
          cmd.clr_token = 1'b1;
          state_next = S_OPER;
          if (stat.tok_present) begin
            priority if (stat.tok_two_points) begin
              cmd.tok_zero = 1'b1;
            end else if (stat.tok_big) begin
              cmd.tok_sat = 1'b1;
            end else begin
              cmd.tdiv_init = 1'b1;
              cnt_next = '0;
              use_mul_next = 1'b0;
              to_operand_next = 1'b1;
              state_next = S_DIV;
            end
          end
        end
      end
      S_OPER: begin
        state_next = S_FIN;
        use_mul_next = 1'b0;
        to_operand_next = 1'b0;
        cnt_next = '0;
        unique case (stat.pending)
          OP_PLUS, OP_MINUS: cmd.addsub = 1'b1;
          OP_TIMES: begin
            cmd.mul_init = 1'b1;
            use_mul_next = 1'b1;
            state_next = S_MUL;
          end
          OP_DIVIDE: begin
            if (stat.den_zero) begin
              cmd.div_zero = 1'b1;
            end else begin
              cmd.div_init = 1'b1;
              state_next = S_DIV;
            end
          end
          default: ;
        endcase
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(MUL_STEPS - 1)) state_next = S_ROUND;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.do_round = 1'b1;
        cmd.round_mul = use_mul;
        state_next = S_PACK;
      end
      S_PACK: begin
        cmd.do_pack = 1'b1;
        cmd.pack_operand = to_operand;
        state_next = to_operand ? S_OPER : S_FIN;
      end
      S_FIN: begin
        cmd.set_pending = 1'b1;
        state_next = stat.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_mul_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> cnt < CNT_W'(MUL_STEPS)) else $error("multiply step count out of range");
  a_round_after_iter: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> $past(state) == S_MUL || $past(state) == S_DIV)
    else $error("round without iteration");
  a_one_init: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.mul_init, cmd.div_init, cmd.tdiv_init, cmd.addsub, cmd.div_zero}))
    else $error("conflicting datapath starts");

endmodule

// ===== rtl/cee_dp.sv =====
module cee_dp #(
  parameter int FRAC_BITS = cee_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cee_pkg::in_item_t  in_data,
  input  cee_pkg::cee_cmd_t  cmd,
  output cee_pkg::cee_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output cee_pkg::out_item_t out_data
);
  import cee_pkg::*;

  localparam int NUM_W = 64 + FRAC_BITS;

  logic [7:0] char_r;
  logic last_r;
  logic [63:0] running, operand;
  logic [MANT_W-1:0] mant;
  logic [FD_W-1:0] frac_digits;
  logic [1:0] pcount;
  logic tpresent;
  op_t pending;
  logic [1:0] err;

  logic [NUM_W-1:0] div_num;
  logic [63:0] div_rem, div_den;
  logic [127:0] mul_p;
  logic [63:0] mul_b;
  logic [MAG_W-1:0] mag;
  logic neg;

  // digit entry
  logic in_digit, in_point;
  logic [63:0] m10d;
  logic fits;
  always_comb begin
    in_digit = in_data.char_code >= CH_ZERO && in_data.char_code <= CH_NINE;
    in_point = in_data.char_code == CH_POINT;
    m10d = ({4'b0, mant} << 3) + ({4'b0, mant} << 1)
         + {60'b0, 4'(in_data.char_code - CH_ZERO)};
    fits = ({4'b0, mant} < DIGIT_LIMIT) && (m10d < DIGIT_LIMIT);
  end

  // operands and arithmetic
  logic [63:0] mag_a, mag_b, sum, diff;
  logic ovf_add, ovf_sub;
  logic [64:0] div_t, mul_sum;
  logic div_ge, rnd_div, rnd_mul;
  logic [127:0] mul_sh;
  logic [128:0] mul_pw;
  logic [MAG_W-1:0] lim;
  logic [63:0] packed_val;
  logic pack_ovf;
  always_comb begin
    mag_a = running[63] ? (~running + 64'd1) : running;
    mag_b = operand[63] ? (~operand + 64'd1) : operand;
    sum = running + operand;
    diff = running - operand;
    ovf_add = (~(running[63] ^ operand[63])) & (running[63] ^ sum[63]);
    ovf_sub = (running[63] ^ operand[63]) & (running[63] ^ diff[63]);
    div_t = {div_rem, div_num[NUM_W-1]};
    div_ge = div_t >= {1'b0, div_den};
    rnd_div = {div_rem, 1'b0} >= {1'b0, div_den};
    mul_sum = {1'b0, mul_p[127:64]} + {1'b0, mul_p[0] ? mul_b : 64'd0};
    mul_sh = mul_p >> FRAC_BITS;
    mul_pw = {mul_p, 1'b0};
    rnd_mul = mul_pw[FRAC_BITS];
    lim = neg ? MAG_W'(SMIN) : MAG_W'(SMAX);
    pack_ovf = mag > lim;
    if (pack_ovf) packed_val = neg ? SMIN : SMAX;
    else packed_val = neg ? (~mag[63:0] + 64'd1) : mag[63:0];
  end

  always_comb begin
    stat.ends = !((char_r >= CH_ZERO && char_r <= CH_NINE) || char_r == CH_POINT) || last_r;
    stat.last = last_r;
    stat.tok_present = tpresent;
    stat.tok_two_points = pcount >= 2'd2;
    stat.tok_big = {4'b0, mant} >= DIGIT_LIMIT;
    stat.den_zero = operand == 64'd0;
    stat.out_busy = out_valid && out_stall;
    stat.pending = pending;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      running <= '0;
      operand <= '0;
      mant <= '0;
      frac_digits <= '0;
      pcount <= '0;
      tpresent <= 1'b0;
      pending <= OP_PLUS;
      err <= '0;
    end else begin
      if (cmd.load) begin
        char_r <= in_data.char_code;
        last_r <= in_data.last_char;
        if (in_digit) begin
          tpresent <= 1'b1;
          if (pcount == 2'd0) begin
            mant <= fits ? m10d[MANT_W-1:0] : DIGIT_LIMIT[MANT_W-1:0];
          end else if (pcount == 2'd1 && fits && frac_digits < FD_W'(MAX_DIGITS)) begin
            mant <= m10d[MANT_W-1:0];
            frac_digits <= frac_digits + 1'b1;
          end
        end else if (in_point) begin
          tpresent <= 1'b1;
          if (pcount < 2'd2) pcount <= pcount + 1'b1;
        end
      end
      if (cmd.clr_token) begin
        mant <= '0;
        frac_digits <= '0;
        pcount <= '0;
        tpresent <= 1'b0;
      end
      if (cmd.tok_zero) operand <= '0;
      if (cmd.tok_sat) begin
        operand <= SMAX;
        err[ERR_OVF] <= 1'b1;
      end
      if (cmd.addsub) begin
        if (pending == OP_PLUS) begin
          running <= ovf_add ? (running[63] ? SMIN : SMAX) : sum;
          if (ovf_add) err[ERR_OVF] <= 1'b1;
        end else begin
          running <= ovf_sub ? (running[63] ? SMIN : SMAX) : diff;
          if (ovf_sub) err[ERR_OVF] <= 1'b1;
        end
      end
      if (cmd.div_zero) begin
        err[ERR_DIV0] <= 1'b1;
        if (running != 64'd0) running <= running[63] ? SMIN : SMAX;
      end
      if (cmd.do_pack) begin
        if (pack_ovf) err[ERR_OVF] <= 1'b1;
        if (cmd.pack_operand) operand <= packed_val;
        else running <= packed_val;
      end
      if (cmd.set_pending) pending <= op_code(char_r);
    end
  end

  // shared divider, multiplier and rounding registers
  always_ff @(posedge clk) begin
    if (cmd.tdiv_init) begin
      div_num <= NUM_W'(mant) << FRAC_BITS;
      div_den <= pow10(frac_digits);
      div_rem <= '0;
      neg <= 1'b0;
    end else if (cmd.div_init) begin
      div_num <= NUM_W'(mag_a) << FRAC_BITS;
      div_den <= mag_b;
      div_rem <= '0;
      neg <= running[63] ^ operand[63];
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? (div_t[63:0] - div_den) : div_t[63:0];
      div_num <= {div_num[NUM_W-2:0], div_ge};
    end
    if (cmd.mul_init) begin
      mul_p <= {64'd0, mag_a};
      mul_b <= mag_b;
      neg <= running[63] ^ operand[63];
    end else if (cmd.mul_step) begin
      mul_p <= {mul_sum, mul_p[63:1]};
    end
    if (cmd.do_round) begin
      if (cmd.round_mul) mag <= MAG_W'(mul_sh) + MAG_W'(rnd_mul);
      else mag <= MAG_W'(div_num) + MAG_W'(rnd_div);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.result_value <= running;
      out_data.status <= err[ERR_DIV0] ? ST_DIV0 : (err[ERR_OVF] ? ST_OVF : ST_OK);
    end
  end

  a_no_emit_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && out_stall)) else $error("result lost in output register");
  a_reset_after_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> running == 64'd0 && pending == OP_PLUS && err == 2'd0)
    else $error("state not cleared after result");
  a_point_range: assert property (@(posedge clk) disable iff (rst)
    pcount != 2'd3) else $error("point count out of range");

endmodule

// ===== rtl/chain_expression_evaluator.sv =====
// Channel | Direction | Payload                               | Handshake
// in      | input     | in_data  (char_code, last_char)       | in_valid / in_stall
// out     | output    | out_data (result_value, status)       | out_valid / out_stall
//
// A digit or point is loaded and decoded. An operator character first converts a typed
// token through the shared restoring divider (one bit a cycle), then applies + and -
// with an add/subtract, and * and / through the multiplier or divider followed by
// rounding and packing. The multiplier is a one-bit-a-cycle shift-and-add over 64 steps.
// Reset (rst, synchronous) returns the calculator to an empty expression.
// The result sits in an output register; a new expression is taken while it waits,
// and a second result stalls input until out_stall drops, as does any non-idle state.
module chain_expression_evaluator #(
  parameter int FRAC_BITS = cee_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cee_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cee_pkg::out_item_t out_data
);
  import cee_pkg::*;

  // command and status between sequencer and datapath
  cee_cmd_t cmd;
  cee_stat_t stat;

  // sequence each transaction: decode, convert token, apply operator, emit
  cee_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat(stat),
    .cmd(cmd)
  );

  // hold expression state, arithmetic units and the output register
  cee_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk),
    .rst(rst),
    .in_data(in_data),
    .cmd(cmd),
    .stat(stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule

// ===== bench/cee_checker.sv =====
module cee_checker #(
  parameter int FRAC_BITS = cee_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  cee_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  cee_pkg::out_item_t out_data,
  output int                 pending,
  output int                 failures
);
  timeunit 1ns;
  timeprecision 1ps;
  import cee_pkg::*;

  logic [63:0] acc_value, prev_operand, mant;
  logic [4:0]  frac_cnt;
  logic [1:0]  points;
  logic        have_token;
  op_t         pend_op;
  logic [1:0]  err_bits;
  out_item_t   answers_due[$];

  function automatic logic [63:0] to_mag(input logic [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  function automatic logic [63:0] saturate(input logic neg, input logic [127:0] v);
    logic [63:0] lim;
    lim = neg ? SMIN : SMAX;
    if (v[127:64] != 0 || v[63:0] > lim) begin
      err_bits[ERR_OVF] = 1'b1;
      return lim;
    end
    return neg ? (~v[63:0] + 64'd1) : v[63:0];
  endfunction

  function automatic logic [63:0] token_fixed();
    logic [63:0]  p, q, r;
    logic [127:0] num, f, rm, total;
    if (points >= 2) return 64'd0;
    if (mant >= DIGIT_LIMIT) begin
      err_bits[ERR_OVF] = 1'b1;
      return SMAX;
    end
    p = pow10(frac_cnt > 18 ? 5'd18 : frac_cnt);
    q = mant / p;
    r = mant % p;
    if (q > (SMAX >> FRAC_BITS)) begin
      err_bits[ERR_OVF] = 1'b1;
      return SMAX;
    end
    num = {64'd0, r} << FRAC_BITS;
    f = num / p;
    rm = num % p;
    if ((rm << 1) >= p) f = f + 1;
    total = ({64'd0, q} << FRAC_BITS) + f;
    if (total > SMAX) begin
      err_bits[ERR_OVF] = 1'b1;
      return SMAX;
    end
    return total[63:0];
  endfunction

  function automatic logic [63:0] combine(input op_t op, input logic [63:0] a,
                                          input logic [63:0] b);
    logic [63:0]  s;
    logic [127:0] prod, num, quo, rm;
    logic         neg;
    neg = a[63] ^ b[63];
    case (op)
      OP_PLUS: begin
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
          err_bits[ERR_OVF] = 1'b1;
          s = a[63] ? SMIN : SMAX;
        end
        return s;
      end
      OP_MINUS: begin
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) begin
          err_bits[ERR_OVF] = 1'b1;
          s = a[63] ? SMIN : SMAX;
        end
        return s;
      end
      OP_TIMES: begin
        prod = {64'd0, to_mag(a)} * {64'd0, to_mag(b)};
        if (FRAC_BITS > 0) prod = (prod >> FRAC_BITS) + ((prod >> (FRAC_BITS - 1)) & 128'd1);
        return saturate(neg, prod);
      end
      OP_DIVIDE: begin
        if (b == 0) begin
          err_bits[ERR_DIV0] = 1'b1;
          if (a == 0) return 64'd0;
          return a[63] ? SMIN : SMAX;
        end
        num = {64'd0, to_mag(a)} << FRAC_BITS;
        quo = num / to_mag(b);
        rm = num % to_mag(b);
        if ((rm << 1) >= to_mag(b)) quo = quo + 1;
        return saturate(neg, quo);
      end
      default: return a;
    endcase
  endfunction

  task automatic clear_all();
    acc_value = 0;
    prev_operand = 0;
    mant = 0;
    frac_cnt = 0;
    points = 0;
    have_token = 0;
    pend_op = OP_PLUS;
    err_bits = 0;
  endtask

  // Advance the calculator model by one character; queue a result on the last one.
  task automatic model_char(input in_item_t it);
    logic        digit, fits;
    logic [63:0] d;
    out_item_t   res;
    digit = it.char_code >= CH_ZERO && it.char_code <= CH_NINE;
    d = 64'(it.char_code - CH_ZERO);
    if (digit) begin
      have_token = 1'b1;
      fits = mant < DIGIT_LIMIT && mant <= (DIGIT_LIMIT - 64'd1 - d) / 10;
      if (points == 0) mant = fits ? mant * 10 + d : DIGIT_LIMIT;
      else if (points == 1 && fits && frac_cnt < MAX_DIGITS) begin
        mant = mant * 10 + d;
        frac_cnt++;
      end
    end else if (it.char_code == CH_POINT) begin
      have_token = 1'b1;
      if (points < 2) points++;
    end
    if ((!digit && it.char_code != CH_POINT) || it.last_char) begin
      if (have_token) prev_operand = token_fixed();
      mant = 0;
      frac_cnt = 0;
      points = 0;
      have_token = 0;
      acc_value = combine(pend_op, acc_value, prev_operand);
      pend_op = op_code(it.char_code);
    end
    if (it.last_char) begin
      res.result_value = acc_value;
      res.status = err_bits[ERR_DIV0] ? ST_DIV0 : (err_bits[ERR_OVF] ? ST_OVF : ST_OK);
      answers_due.push_back(res);
      clear_all();
    end
  endtask

  initial begin
    clear_all();
    failures = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      clear_all();
    end else begin
      if (in_valid && !in_stall) model_char(in_data);
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result value=%h status=%0d", $time,
                   out_data.result_value, out_data.status);
          failures++;
        end else begin
          want = answers_due.pop_front();
          if (want.result_value !== out_data.result_value) begin
            $display("%0t: result_value expected %h actual %h", $time,
                     want.result_value, out_data.result_value);
            failures++;
          end
          if (want.status !== out_data.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_data.status);
            failures++;
          end
        end
      end
    end
    pending = answers_due.size();
  end
endmodule

// ===== bench/tb_chain_expression_evaluator.sv =====
module tb_chain_expression_evaluator;
  timeunit 1ns;
  timeprecision 1ps;
  import cee_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  out_item_t out_data;
  int        pending, failures;
  int        char_count = 0;
  int        cycles = 0;
  int        hold_left = 3;
  logic      calm = 1'b0;
  logic      drained = 1'b0;

  chain_expression_evaluator dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  cee_checker chk (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .pending, .failures
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: hold out_stall for a freshly drawn number of cycles per transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        hold_left = calm ? 0 : $urandom_range(0, 8);
        out_stall <= (hold_left != 0);
      end else if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= (hold_left != 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Present one character after a random gap and hold it until it is accepted.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{char_code: c, last_char: last};
    do @(posedge clk); while (in_stall);
    char_count++;
  endtask

  // Send a string as one expression; the final character carries the last flag.
  task automatic send_expr(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_token();
    int len, pt;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 21) : $urandom_range(0, 4);
    pt = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == pt) send_char(CH_POINT, 1'b0);
      send_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
    end
    if (pt == len || $urandom_range(0, 30) == 0) send_char(CH_POINT, 1'b0);
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 9))
      0, 1: return CH_PLUS;
      2, 3: return CH_MINUS;
      4, 5, 6: return CH_TIMES;
      7, 8: return CH_DIVIDE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_expr();
    int terms;
    terms = $urandom_range(1, 6);
    for (int t = 0; t < terms; t++) begin
      send_token();
      if (t == terms - 1) begin
        if ($urandom_range(0, 3) == 0) send_char(pick_operator(), 1'b1);
        else send_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b1);
      end else begin
        send_char(pick_operator(), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: every operator, token corner cases, saturation and divide by zero.
    send_expr("1+2");
    send_expr("7-9.25");
    send_expr("1.5*2.5");
    send_expr("10/4");
    send_expr("8/0");
    send_expr("0/0");
    send_expr("-3/0");
    send_expr("1..2+5");
    send_expr(".+5.+.5");
    send_expr("3*+");
    send_expr("9999999999999999999+1");
    send_expr("0.1234567890123456789012");
    send_expr("999999999999*999999999999");
    send_expr("-999999999999*999999999999");
    send_expr("9x4");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_expr("5");

    // Random expressions, with a calm stretch and a full drain halfway through.
    while (char_count < 1320) begin
      calm = (char_count > 500 && char_count < 650);
      if (!drained && char_count > 700) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if ($urandom_range(0, 19) == 0) send_char(8'($urandom_range(0, 255)), 1'b0);
      random_expr();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== chain_expression_evaluator.f =====
rtl/cee_pkg.sv
rtl/cee_ctrl.sv
rtl/cee_dp.sv
rtl/chain_expression_evaluator.sv
bench/cee_checker.sv
bench/tb_chain_expression_evaluator.sv
